FILE: src/kls_pkg.sv
// kls_pkg: word types and fixed constants for the k-th largest selector.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package kls_pkg;

  localparam int SAMPLE_W = 16;
  localparam int RANK_W   = 4;

  localparam logic [RANK_W-1:0] RANK_RESET = RANK_W'(1);

  // Input word: one value of a set plus its framing marks.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       first_of_set;
    logic                       last_of_set;
  } kls_in_t;

  // Output word: one per input word.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] selected;
    logic                       found;
  } kls_out_t;

endpackage

FILE: src/kls_cell.sv
// kls_cell: one slot of the descending insertion chain.
// Depends on kls_pkg; instantiated KEEP times by kth_largest_of_set_top.
`timescale 1ns / 1ps

module kls_cell import kls_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                       clk_i,
  input  logic                       en_i,       // word accepted this cycle
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic [CW-1:0]              held_i,     // occupied slots before insert
  input  logic                       prev_ge_i,  // left neighbor keeps its value
  input  logic signed [SAMPLE_W-1:0] prev_val_i, // left neighbor's value
  output logic                       ge_o,
  output logic signed [SAMPLE_W-1:0] val_o,
  output logic signed [SAMPLE_W-1:0] nxt_o
);

  logic signed [SAMPLE_W-1:0] val_q, val_d;
  logic                       occupied;

  assign occupied = CW'(IDX) < held_i;
  assign ge_o     = occupied && (val_q >= sample_i);

  // Keep own value, take the new sample, or shift in from the left.
  always_comb begin
    if (ge_o) begin
      val_d = val_q;
    end else if (prev_ge_i) begin
      val_d = sample_i;
    end else begin
      val_d = prev_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;
  assign nxt_o = val_d;

endmodule

FILE: src/kls_skid.sv
// kls_skid: two-entry output buffer (output register plus skid register).
// Depends on kls_pkg; instantiated by kth_largest_of_set_top.
`timescale 1ns / 1ps

module kls_skid import kls_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,      // new result this cycle
  input  kls_out_t word_i,
  output logic     full_o,      // no room for another result
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output kls_out_t out_word_o
);

  logic     out_valid_q, out_valid_d;
  logic     skid_valid_q, skid_valid_d;
  kls_out_t out_word_q, out_word_d;
  kls_out_t skid_word_q, skid_word_d;
  logic     out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_word_d   = out_word_q;
    skid_word_d  = skid_word_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_word_d   = skid_word_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_word_d  = word_i;
        out_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_word_d  = word_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q  <= out_word_d;
    skid_word_q <= skid_word_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

FILE: src/kth_largest_of_set_top.sv
// kth_largest_of_set_top: streaming k-th largest selection over framed sets.
// Depends on kls_pkg, kls_cell and kls_skid.
`timescale 1ns / 1ps

// Usage
//  - Input channel (in_valid_i / in_stall_o / in_word_i): one sample per word,
//    tagged first_of_set / last_of_set. A word is taken at a clock edge with
//    valid high and stall low.
//  - Output channel (out_valid_o / out_stall_i / out_word_o): exactly one word
//    per input word, in order. On a last word with more than rank samples held,
//    selected is the sample at zero-based rank in descending order and found
//    is set; every other word yields zero with found clear.
//  - Config: cfg_we_i writes cfg_data_i into rank (capped at KEEP-1). Write
//    only while no words are in flight.
//  - Result: computed from the accepted word and registered in the output buffer.
//  - Throughput: 1 word per cycle while in_stall_o is low; the KEEP cells compare
//    against the new sample in parallel and each shifts from its left neighbor.
//  - Stall: a two-entry output buffer absorbs one extra result, so input
//    is still taken after the receiver stalls until the skid entry fills;
//    after that in_stall_o stays high until the receiver takes a word.
//  - Reset: held count cleared, rank back to 1, output buffer empty. The cell
//    values are not reset; slots beyond the held count are never read.
module kth_largest_of_set_top import kls_pkg::*; #(
  parameter int KEEP = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  kls_in_t           in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output kls_out_t          out_word_o,
  input  logic              cfg_we_i,
  input  logic [RANK_W-1:0] cfg_data_i
);

  localparam int CW = $clog2(KEEP + 1);  // held count, 0..KEEP
  localparam int IW = $clog2(KEEP);      // slot index

  logic [RANK_W-1:0] rank_q;
  logic [CW-1:0]     held_q, held_d;
  logic [CW-1:0]     held_before;  // occupied slots seen by the insert
  logic [CW-1:0]     held_after;
  logic [IW-1:0]     r_sel;
  logic              accept;
  logic              buf_full;
  logic              hit;
  kls_out_t          res;

  logic                       cell_ge  [KEEP];
  logic signed [SAMPLE_W-1:0] cell_val [KEEP];
  logic signed [SAMPLE_W-1:0] cell_nxt [KEEP];

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  // A first word drops whatever the previous set left.
  assign held_before = in_word_i.first_of_set ? '0 : held_q;
  assign held_after  = (held_before < CW'(KEEP)) ? held_before + CW'(1) : held_before;

  // Insertion chain: slot 0 sees an always-keeping neighbor.
  for (genvar i = 0; i < KEEP; i++) begin : g_cell
    logic                       prev_ge;
    logic signed [SAMPLE_W-1:0] prev_val;
    if (i == 0) begin : g_head
      assign prev_ge  = 1'b1;
      assign prev_val = in_word_i.sample;
    end else begin : g_body
      assign prev_ge  = cell_ge[i-1];
      assign prev_val = cell_val[i-1];
    end
    kls_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk_i      (clk_i),
      .en_i       (accept),
      .sample_i   (in_word_i.sample),
      .held_i     (held_before),
      .prev_ge_i  (prev_ge),
      .prev_val_i (prev_val),
      .ge_o       (cell_ge[i]),
      .val_o      (cell_val[i]),
      .nxt_o      (cell_nxt[i])
    );
  end

  // Rank capped to the last slot.
  assign r_sel = (int'(rank_q) > KEEP - 1) ? IW'(KEEP - 1) : IW'(rank_q);
  assign hit   = in_word_i.last_of_set && (int'(held_after) > int'(r_sel));

  always_comb begin
    res.selected = hit ? cell_nxt[r_sel] : '0;
    res.found    = hit;
  end

  // A reported selection empties the set.
  always_comb begin
    held_d = held_q;
    if (accept) begin
      held_d = hit ? '0 : held_after;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      rank_q <= RANK_RESET;
    end else begin
      held_q <= held_d;
      if (cfg_we_i) begin
        rank_q <= cfg_data_i;
      end
    end
  end

  kls_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .word_i      (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

FILE: verif/kls_checker.sv
// kls_checker: watches both word channels and the rank port of the k-th
// largest selector, predicts each result word and compares it. Needs kls_pkg.
`timescale 1ns / 1ps

module kls_checker import kls_pkg::*; #(
  parameter int KEEP = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  kls_in_t           in_word_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  kls_out_t          out_word_i,
  input  logic              cfg_we_i,
  input  logic [RANK_W-1:0] cfg_data_i,
  output int                mismatch_count_o,
  output int                pending_o
);

  // predicted block state
  logic signed [SAMPLE_W-1:0] kept_vals [KEEP];
  int unsigned                kept_count;
  logic [RANK_W-1:0]          rank_q;
  kls_out_t                   expected_words [$];
  kls_out_t                   want;

  // Insert the sample into the descending list, then select on a last word.
  function automatic kls_out_t select_word(kls_in_t w);
    logic signed [SAMPLE_W-1:0] v;
    int unsigned                n;
    int unsigned                pos;
    int unsigned                top_idx;
    int unsigned                r;
    int unsigned                i;
    kls_out_t                   res;
    v   = w.sample;
    res = '0;
    if (w.first_of_set) kept_count = 0;
    n   = (kept_count < KEEP) ? kept_count : KEEP;
    pos = 0;
    while (pos < n && kept_vals[pos] >= v) pos++;
    if (pos < KEEP) begin
      top_idx = (n < KEEP) ? n : KEEP - 1;
      for (i = top_idx; i > pos; i--) kept_vals[i] = kept_vals[i-1];
      kept_vals[pos] = v;
    end
    if (kept_count < KEEP) kept_count++;
    if (w.last_of_set) begin
      r = (rank_q > KEEP - 1) ? KEEP - 1 : rank_q;
      if (kept_count > r) begin
        res.selected = kept_vals[r];
        res.found    = 1'b1;
        kept_count   = 0;
      end
    end
    return res;
  endfunction

  task automatic report_bad(input string what, input kls_out_t exp_w, input kls_out_t got_w);
    mismatch_count_o++;
    if (mismatch_count_o <= 10)
      $display("%0t: %s: expected selected=%0d found=%0b, got selected=%0d found=%0b",
               $realtime, what, exp_w.selected, exp_w.found, got_w.selected, got_w.found);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_count       = 0;
      rank_q           = RANK_RESET;
      expected_words.delete();
      pending_o        = 0;
      mismatch_count_o = 0;
    end else begin
      // a result can't come from a word taken at this same edge: compare first
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          report_bad("result word with nothing expected", '0, out_word_i);
        end else begin
          want = expected_words.pop_front();
          if (want.selected !== out_word_i.selected || want.found !== out_word_i.found)
            report_bad("result word mismatch", want, out_word_i);
        end
      end
      if (cfg_we_i) rank_q = cfg_data_i;
      if (in_valid_i && !in_stall_i)
        expected_words.insert(expected_words.size(), select_word(in_word_i));
      pending_o = expected_words.size();
    end
  end

endmodule

FILE: verif/testbench.sv
// testbench: stimulus and verdict for kth_largest_of_set_top; framed sets of
// samples under random rank settings. Needs kls_pkg, kls_checker and the RTL.
`timescale 1ns / 1ps

module testbench;
  import kls_pkg::*;

  localparam int KEEP        = 16;
  localparam int PHASE_WORDS = 230;
  localparam int HOLD_CYCLES = 80;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_e;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  kls_in_t           in_word_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  kls_out_t          out_word_o;
  logic              cfg_we_i    = 1'b0;
  logic [RANK_W-1:0] cfg_data_i  = '0;

  int mismatch_count;
  int pending_words;

  // sender burst state, receiver stall state
  int                         burst_left  = 0;
  bit                         hold_req    = 1'b0;
  int                         hold_left   = 0;
  int                         seg_left    = 0;
  stall_mode_e                seg_mode    = STALL_NONE;
  logic signed [SAMPLE_W-1:0] prev_sample = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  kth_largest_of_set_top #(.KEEP(KEEP)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  kls_checker #(.KEEP(KEEP)) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_word_i        (in_word_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_word_i       (out_word_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_words)
  );

  // Receiver: stall in segments of random mode and length. A hold request
  // forces a long stall so the output buffer fills and in_stall_o rises.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_mode = stall_mode_e'($urandom_range(0, 3));
        seg_left = $urandom_range(4, 40);
      end
      seg_left--;
      case (seg_mode)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
        default:     out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  function automatic kls_in_t make_word(logic [SAMPLE_W-1:0] s, logic f, logic l);
    kls_in_t w;
    w.sample       = s;
    w.first_of_set = f;
    w.last_of_set  = l;
    return w;
  endfunction

  // Mostly full-range values, with extremes, tiny values and repeats for ties.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic signed [SAMPLE_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = prev_sample;
      1:       v = 16'sh7FFF;
      2:       v = 16'sh8000;
      3:       v = SAMPLE_W'($urandom_range(0, 7)) - 16'sd4;
      default: v = SAMPLE_W'($urandom);
    endcase
    prev_sample = v;
    return v;
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  // valid stays high between words of a burst and drops only for a gap.
  task automatic send_word(input kls_in_t w);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 10);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
    burst_left = 0;
  endtask

  // Rank changes only with the pipe empty.
  task automatic write_rank(input logic [RANK_W-1:0] r);
    while (pending_words != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= r;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Well-formed sets of random length, with some stray words carrying random
  // marks (unframed data, double firsts, lasts with too few values).
  task automatic run_phase(input int words);
    int sent;
    int len;
    int k;
    sent = 0;
    while (sent < words) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(make_word(SAMPLE_W'($urandom), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1))));
        sent++;
      end else begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
        for (k = 0; k < len; k++)
          send_word(make_word(pick_sample(), k == 0, k == len - 1));
        sent += len;
      end
    end
  endtask

  initial begin
    int            ph;
    int            k;
    logic [15:0]   v;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, rank at its reset value of one.
    // One-word set: too few values, nothing found, value kept.
    send_word(make_word(16'h7FFF, 1'b1, 1'b1));
    // Continues the kept value without a first mark; min value at rank one.
    send_word(make_word(16'h8000, 1'b0, 1'b1));
    // Non-last words then equal values; -1 is reported.
    send_word(make_word(16'h0000, 1'b1, 1'b0));
    send_word(make_word(16'hFFFF, 1'b0, 1'b0));
    send_word(make_word(16'hFFFF, 1'b0, 1'b1));
    // Set longer than the store: only the largest survive, count saturates.
    for (k = 0; k < 18; k++) begin
      if (k == 0)          v = 16'h8000;
      else if (k == 17)    v = 16'h7FFF;
      else if (k % 4 == 1) v = 16'h0100;
      else                 v = 16'(k * 1700 - 14000);
      send_word(make_word(v, k == 0, k == 17));
    end

    // Random phases, each behind a drained pipe and a new rank. The drain is
    // also the sender's full pause.
    for (ph = 0; ph < 6; ph++) begin
      stop_sending();
      case (ph)
        0:       write_rank('0);
        1:       write_rank('1);
        default: write_rank(RANK_W'($urandom_range(0, 15)));
      endcase
      if (ph == 2) hold_req = 1'b1;
      run_phase(PHASE_WORDS);
    end
    stop_sending();

    while (pending_words != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
